// ----- hdl/sic_pkg.sv -----
// Package for the streaming inversion counter: sizes, limits and the item
// record that moves down the row of compare cells. No dependencies.
`default_nettype none

package sic_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int GAP_W     = $clog2(MAX_ITEMS);
    localparam int POS_W     = $clog2(MAX_ITEMS + 1);
    localparam int SAMPLE_W  = 32;
    localparam int GREATER_W = 10;
    localparam int TOTAL_W   = 19;

    localparam logic [GREATER_W-1:0] GREATER_MAX = '1;
    localparam logic [TOTAL_W-1:0]   TOTAL_MAX   = '1;

    // One item on its way through the row. The gap field counts the cells
    // still to pass before the one that will hold this sample.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] sample;
        logic [GAP_W-1:0]           gap;
        logic                       done;
        logic                       ovf;
        logic                       start;
        logic [GREATER_W-1:0]       count;
    } item_t;

endpackage

`default_nettype wire

// ----- hdl/sic_in_if.sv -----
// Input channel of the streaming inversion counter: valid/ready handshake with
// the sample and the start flag. Depends on sic_pkg.
`default_nettype none

interface sic_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [sic_pkg::SAMPLE_W-1:0] sample_value;
    logic                                starts_sequence;

    modport source (output valid, output sample_value, output starts_sequence, input ready);
    modport sink   (input valid, input sample_value, input starts_sequence, output ready);
endinterface

`default_nettype wire

// ----- hdl/sic_out_if.sv -----
// Result channel of the streaming inversion counter: valid/ready handshake with
// the per-item count, the running total and the overflow flag. Depends on sic_pkg.
`default_nettype none

interface sic_out_if;
    logic                           valid;
    logic                           ready;
    logic [sic_pkg::GREATER_W-1:0]  greater_before;
    logic [sic_pkg::TOTAL_W-1:0]    running_total;
    logic                           store_overflow;

    modport source (output valid, output greater_before, output running_total,
                    output store_overflow, input ready);
    modport sink   (input valid, input greater_before, input running_total,
                    input store_overflow, output ready);
endinterface

`default_nettype wire

// ----- hdl/sic_cell.sv -----
// One compare cell: holds one stored sample, counts it against passing items
// and captures the item whose gap has run out. Depends on sic_pkg.
`default_nettype none

module sic_cell (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire sic_pkg::item_t item_in,
    output sic_pkg::item_t      item_out
);

    sic_pkg::item_t                      item_reg;
    sic_pkg::item_t                      item_next;
    logic signed [sic_pkg::SAMPLE_W-1:0] stored_reg;
    logic                                capture;

    always_comb
    begin
        item_next = item_in;
        capture   = 1'b0;
        if (item_in.valid && !item_in.done && !item_in.ovf)
        begin
            if (item_in.gap == '0)
            begin
                item_next.done = 1'b1;
                capture        = 1'b1;
            end
            else
            begin
                // Every cell ahead of the capture point holds an earlier sample
                // of the same sequence.
                item_next.gap = item_in.gap - 1'b1;
                if ((stored_reg > item_in.sample) && (item_in.count != sic_pkg::GREATER_MAX))
                begin
                    item_next.count = item_in.count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (adv)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && capture)
        begin
            stored_reg <= item_in.sample;
        end
    end

    assign item_out = item_reg;

endmodule

`default_nettype wire

// ----- hdl/sic_chain.sv -----
// Row of MAX_ITEMS compare cells, each handing its item to the next one on
// every advance. Depends on sic_pkg and sic_cell.
`default_nettype none

module sic_chain (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           adv,
    input  wire sic_pkg::item_t head,
    output sic_pkg::item_t      tail
);

    sic_pkg::item_t links [sic_pkg::MAX_ITEMS+1];

    assign links[0] = head;

    for (genvar i = 0; i < sic_pkg::MAX_ITEMS; i++)
    begin : g_cell
        sic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .item_in  (links[i]),
            .item_out (links[i+1])
        );
    end

    assign tail = links[sic_pkg::MAX_ITEMS];

endmodule

`default_nettype wire

// ----- hdl/stream_inversion_counter.sv -----
// Streaming inversion counter: position counter at the entry, a row of
// MAX_ITEMS compare cells, running total and output register at the exit.
// Throughput: one item per cycle unless a result waits. Each item passes through
// the MAX_ITEMS cell registers and then the output register. The whole row stalls while
// a result waits. Reset clears the position, the total and all valid flags.
`default_nettype none

module stream_inversion_counter (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sic_in_if.sink     samples,
    sic_out_if.source  results
);

    logic                              adv;
    logic [sic_pkg::POS_W-1:0]         pos_reg;
    logic [sic_pkg::POS_W-1:0]         pos_next;
    logic [sic_pkg::POS_W-1:0]         pos_cur;
    logic                              entry_ovf;
    sic_pkg::item_t                    head;
    sic_pkg::item_t                    tail;

    logic                              out_valid_reg;
    logic [sic_pkg::GREATER_W-1:0]     greater_reg;
    logic                              ovf_reg;
    logic [sic_pkg::TOTAL_W-1:0]       total_reg;
    logic [sic_pkg::TOTAL_W-1:0]       total_next;
    logic [sic_pkg::TOTAL_W-1:0]       total_base;
    logic [sic_pkg::TOTAL_W:0]         total_sum;

    assign adv           = !out_valid_reg || results.ready;
    assign samples.ready = adv;

    // Entry: the item's place in its sequence decides which cell keeps it.
    always_comb
    begin
        pos_cur   = samples.starts_sequence ? '0 : pos_reg;
        entry_ovf = (pos_cur >= sic_pkg::POS_W'(sic_pkg::MAX_ITEMS));
        pos_next  = pos_reg;
        if (samples.valid)
        begin
            pos_next = entry_ovf ? pos_cur : (pos_cur + 1'b1);
        end
        head.valid  = samples.valid;
        head.sample = samples.sample_value;
        head.gap    = pos_cur[sic_pkg::GAP_W-1:0];
        head.done   = 1'b0;
        head.ovf    = entry_ovf;
        head.start  = samples.starts_sequence;
        head.count  = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (adv)
        begin
            pos_reg <= pos_next;
        end
    end

    sic_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .head  (head),
        .tail  (tail)
    );

    // Exit: saturating running total in item order.
    always_comb
    begin
        total_base = tail.start ? '0 : total_reg;
        total_sum  = {1'b0, total_base} + {{(sic_pkg::TOTAL_W+1-sic_pkg::GREATER_W){1'b0}},
                                           tail.count};
        total_next = total_reg;
        if (tail.valid)
        begin
            if (tail.ovf)
            begin
                total_next = total_base;
            end
            else if (total_sum[sic_pkg::TOTAL_W])
            begin
                total_next = sic_pkg::TOTAL_MAX;
            end
            else
            begin
                total_next = total_sum[sic_pkg::TOTAL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else if (adv)
        begin
            out_valid_reg <= tail.valid;
            total_reg     <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            greater_reg <= tail.ovf ? '0 : tail.count;
            ovf_reg     <= tail.ovf;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.greater_before = greater_reg;
    assign results.running_total  = total_reg;
    assign results.store_overflow = ovf_reg;

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= sic_pkg::POS_W'(sic_pkg::MAX_ITEMS))
        else $error("sequence position beyond store capacity");

    a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.store_overflow |-> results.greater_before == '0)
        else $error("dropped item reports a nonzero count");

    a_total_covers: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.store_overflow |->
            results.running_total >= sic_pkg::TOTAL_W'(results.greater_before))
        else $error("running total below the item's own count");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pos_reg) && $stable(total_reg))
        else $error("entry or exit state moved during a stall");

endmodule

`default_nettype wire

// ----- verif/tb_stream_inversion_counter.sv -----
// Self-checking testbench for stream_inversion_counter: random bursts of samples
// against an in-bench inversion predictor, with random result back-pressure.
// Depends on sic_pkg, sic_in_if, sic_out_if and the block itself.

module tb_stream_inversion_counter;

    localparam int ROW_LATENCY  = sic_pkg::MAX_ITEMS + 1;
    localparam int HOLD_CYCLES  = 2500;
    localparam int STALL_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 150;

    localparam logic signed [sic_pkg::SAMPLE_W-1:0] SAMPLE_HI =
        {1'b0, {(sic_pkg::SAMPLE_W-1){1'b1}}};
    localparam logic signed [sic_pkg::SAMPLE_W-1:0] SAMPLE_LO =
        {1'b1, {(sic_pkg::SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic [sic_pkg::GREATER_W-1:0] greater;
        logic [sic_pkg::TOTAL_W-1:0]   total;
        logic                          overflow;
    } count_result_t;

    // Keeps its own copy of the current sequence and the running total, and
    // queues the counts each accepted sample should produce.
    class inversion_ledger;
        logic signed [sic_pkg::SAMPLE_W-1:0] kept [sic_pkg::MAX_ITEMS];
        int unsigned                         kept_count;
        int unsigned                         total;
        count_result_t                       owed [$];
        int unsigned                         errors;
        int unsigned                         checked;

        function new();
            kept_count = 0;
            total      = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void take_sample(logic signed [sic_pkg::SAMPLE_W-1:0] v, logic first);
            count_result_t r;
            int unsigned   above;
            above      = 0;
            r.overflow = 1'b0;
            if (first)
            begin
                kept_count = 0;
                total      = 0;
            end
            if (kept_count >= sic_pkg::MAX_ITEMS)
                r.overflow = 1'b1;
            else
            begin
                for (int i = 0; i < kept_count; i++)
                    if (kept[i] > v)
                        above++;
                kept[kept_count] = v;
                kept_count++;
                if (above > sic_pkg::GREATER_MAX)
                    above = sic_pkg::GREATER_MAX;
                total = (total + above > sic_pkg::TOTAL_MAX) ? sic_pkg::TOTAL_MAX
                                                             : total + above;
            end
            r.greater = sic_pkg::GREATER_W'(above);
            r.total   = sic_pkg::TOTAL_W'(total);
            owed.push_back(r);
        endfunction

        task report(string what, int unsigned want, int unsigned got);
            errors++;
            $display("[%0t] result %0d: %s expected %0d, got %0d",
                     $time, checked, what, want, got);
        endtask

        task match_result(logic [sic_pkg::GREATER_W-1:0] g, logic [sic_pkg::TOTAL_W-1:0] t,
                          logic o);
            count_result_t w;
            if (owed.size() == 0)
                report("result with nothing outstanding, greater_before", 0, g);
            else
            begin
                w = owed.pop_front();
                if (g !== w.greater)
                    report("greater_before", w.greater, g);
                if (t !== w.total)
                    report("running_total", w.total, t);
                if (o !== w.overflow)
                    report("store_overflow", w.overflow, o);
            end
            checked++;
        endtask

        function int unsigned outstanding();
            return owed.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sic_in_if  samples_ch();
    sic_out_if results_ch();

    stream_inversion_counter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch)
    );

    inversion_ledger ledger = new();

    int unsigned burst_left  = 10;
    bit          steady      = 1'b0;
    bit          hold_wanted = 1'b0;
    bit          hold_served = 1'b0;
    int unsigned quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (samples_ch.valid && samples_ch.ready)
                ledger.take_sample(samples_ch.sample_value, samples_ch.starts_sequence);
            if (results_ch.valid && results_ch.ready)
                ledger.match_result(results_ch.greater_before, results_ch.running_total,
                                    results_ch.store_overflow);
        end
    end

    // Any accepted item on either side counts as progress.
    always @(posedge clk)
    begin
        if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: stretches of always-ready, random and periodic stalls, plus
    // one long hold-off that lets the whole row fill and block the input.
    initial
    begin
        int unsigned mode;
        int unsigned len;
        int unsigned k;
        results_ch.ready = 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_wanted && !hold_served)
            begin
                hold_served = 1'b1;
                results_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                len  = $urandom_range(10, 200);
                k    = 0;
                while (k < len && !(hold_wanted && !hold_served))
                begin
                    case (mode)
                        0: results_ch.ready <= 1'b1;
                        1: results_ch.ready <= ($urandom_range(0, 3) != 0);
                        2: results_ch.ready <= 1'($urandom_range(0, 1));
                        default: results_ch.ready <= ((k % 7) >= 2);
                    endcase
                    @(posedge clk);
                    k++;
                end
            end
        end
    end

    task automatic offer(input logic signed [sic_pkg::SAMPLE_W-1:0] v, input logic first);
        samples_ch.valid           <= 1'b1;
        samples_ch.sample_value    <= v;
        samples_ch.starts_sequence <= first;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause_sender();
        int unsigned gap;
        if (steady)
            return;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 20);
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
    endtask

    // Mix of full-range values, the two extremes and a narrow band near zero
    // so that equal samples show up often.
    function automatic logic signed [sic_pkg::SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        int          near_zero;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return SAMPLE_HI;
        if (pick == 1)
            return SAMPLE_LO;
        if (pick < 5)
        begin
            near_zero = int'($urandom_range(0, 8)) - 4;
            return near_zero;
        end
        return $urandom;
    endfunction

    initial
    begin
        int unsigned                         random_items;
        int unsigned                         len;
        logic signed [sic_pkg::SAMPLE_W-1:0] v;
        rst_n                      = 1'b0;
        samples_ch.valid           = 1'b0;
        samples_ch.sample_value    = '0;
        samples_ch.starts_sequence = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a sequence begun without a start flag, both extremes, equal
        // values, a start in mid-sequence and a one-item sequence right before another start.
        offer(5, 1'b0);          pause_sender();
        offer(SAMPLE_HI, 1'b0);  pause_sender();
        offer(SAMPLE_LO, 1'b0);  pause_sender();
        offer(0, 1'b0);          pause_sender();
        offer(-1, 1'b0);         pause_sender();
        offer(0, 1'b0);          pause_sender();
        offer(SAMPLE_LO, 1'b0);  pause_sender();
        offer(SAMPLE_HI, 1'b0);  pause_sender();
        offer(1, 1'b1);          pause_sender();
        offer(0, 1'b0);          pause_sender();
        offer(SAMPLE_HI, 1'b1);  pause_sender();
        offer(SAMPLE_LO, 1'b1);  pause_sender();
        offer(-2, 1'b0);         pause_sender();
        offer(-3, 1'b0);         pause_sender();

        // Random sequences, mostly short; a few carry on without a start flag
        // or are cut by a stray one.
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(1, 24);
            for (int k = 0; k < len; k++)
            begin
                offer(random_sample(), (k == 0) ? ($urandom_range(0, 7) != 0)
                                                : ($urandom_range(0, 39) == 0));
                pause_sender();
                random_items++;
            end
        end

        // A strictly falling sequence that fills the store and drives the last item's
        // count to its largest value, sent without gaps while the result side holds
        // off. The items past the store's capacity must come back as overflow.
        hold_wanted = 1'b1;
        steady      = 1'b1;
        v = SAMPLE_HI;
        for (int k = 0; k < sic_pkg::MAX_ITEMS; k++)
        begin
            offer(v, k == 0);
            v = v - $urandom_range(1, 2000000);
        end
        for (int k = 0; k < 6; k++)
            offer(random_sample(), 1'b0);
        steady = 1'b0;
        pause_sender();

        // A start while the store is full, then a short random tail.
        offer(random_sample(), 1'b1);
        pause_sender();
        for (int k = 0; k < 20; k++)
        begin
            offer(random_sample(), $urandom_range(0, 4) == 0);
            pause_sender();
        end

        samples_ch.valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (ROW_LATENCY + 20) @(posedge clk);
        if (ledger.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
